// ===== rtl/ffha_pkg.sv =====
`timescale 1ns / 1ps
// Shared types for the first-fit heap allocator: result codes, controller
// states, datapath commands and datapath status. No dependencies.
package ffha_pkg;

	typedef enum logic [1:0] {
		RES_DONE     = 2'd0,
		RES_NOFIT    = 2'd1,
		RES_NOTFOUND = 2'd2
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_RD,
		S_EV,
		S_SPLIT_WR,
		S_RD_N,
		S_EV_N,
		S_WR_T,
		S_FIN
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_PREP,
		OP_RD_CUR,
		OP_EVAL,
		OP_WR_CUR,
		OP_RD_NXT,
		OP_EVAL_NXT,
		OP_WR_TGT,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		logic is_rel;
		logic hit;
		logic split;
		logic last;
	} dp_stat_t;

endpackage

// ===== rtl/ffha_ram.sv =====
`timescale 1ns / 1ps
// Block header store: one write and one registered read per cycle.
// No package dependency.
module ffha_ram #(
	parameter int DEPTH = 512,
	parameter int AW = 9,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/ffha_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the allocator: request registers, chain walk registers, the
// header store and the result registers. Depends on ffha_pkg and ffha_ram.
module ffha_dp #(
	parameter int HEAP_BYTES = 4096,
	parameter int ALIGN_BYTES = 8,
	parameter int HEADER_BYTES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ffha_pkg::dp_op_t  op,
	output ffha_pkg::dp_stat_t stat,
	input  logic              req_type,
	input  logic [12:0]       request_size,
	input  logic [11:0]       release_addr,
	output logic [1:0]        status,
	output logic [11:0]       payload_addr,
	output logic [12:0]       free_bytes
);
	import ffha_pkg::*;

	localparam int UNITS = HEAP_BYTES / ALIGN_BYTES;
	localparam int HSIZE = UNITS * ALIGN_BYTES;
	localparam int HDR = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
	localparam int IW = $clog2(UNITS + 1);
	localparam int AW = $clog2(UNITS);
	localparam int BW = $clog2(HSIZE + 1);
	localparam int NW = (BW > 14) ? BW + 1 : 15;
	localparam int DW = IW + BW + 1;
	localparam int RS = 24;
	localparam logic [RS-1:0] RM_C = RS'((2 ** RS + ALIGN_BYTES - 1) / ALIGN_BYTES);
	localparam logic [IW-1:0] END_IDX = IW'(UNITS);
	localparam logic [BW-1:0] HSIZE_C = BW'(HSIZE);

	logic          rel_q;
	logic [11:0]   rel_addr_q;
	logic [NW-1:0] units_q;
	logic [NW-1:0] need_q;
	logic [IW-1:0] cur_q;
	logic [IW-1:0] steps_q;
	logic [IW-1:0] prev_q;
	logic          prev_valid_q;
	logic          prev_busy_q;
	logic [BW-1:0] prev_bytes_q;
	logic [IW-1:0] tgt_q;
	logic [IW-1:0] tgt_next_q;
	logic [BW-1:0] tgt_bytes_q;
	logic          nok_q;
	logic [BW-1:0] free_q;
	logic          init0_q;
	logic          rsel0_q;
	res_t          r_status_q;
	logic [11:0]   r_addr_q;
	res_t          o_status_q;
	logic [11:0]   o_addr_q;
	logic [12:0]   o_free_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [DW-1:0] wdata;
	logic          re;
	logic [AW-1:0] raddr;
	logic [DW-1:0] ram_rdata;
	logic [DW-1:0] rd_data;
	logic [IW-1:0] rd_next;
	logic [BW-1:0] rd_bytes;
	logic          rd_busy;

	logic [NW-1:0]    x_w;
	logic [NW+RS-1:0] prod_w;
	logic             fit;
	logic [NW:0]      rem_w;
	logic             split_ok;
	logic [31:0]      pay_w;
	logic             rel_hit;
	logic [IW:0]      steps_inc;
	logic             last;
	logic [BW-1:0]    chg;
	logic             pm;
	logic [31:0]      free_w;

	ffha_ram #(.DEPTH(UNITS), .AW(AW), .DW(DW)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// Entry 0 reads as the whole heap until it is first written.
	assign rd_data  = rsel0_q ? {END_IDX, HSIZE_C, 1'b0} : ram_rdata;
	assign rd_next  = rd_data[DW-1 -: IW];
	assign rd_bytes = rd_data[BW:1];
	assign rd_busy  = rd_data[0];

	// Request size plus header, rounded up in alignment units by a reciprocal.
	assign x_w    = NW'(request_size) + NW'(HDR + ALIGN_BYTES - 1);
	assign prod_w = x_w * RM_C;

	assign fit       = !rd_busy && (NW'(rd_bytes) >= need_q);
	assign rem_w     = (NW+1)'(cur_q) + (NW+1)'(units_q);
	assign split_ok  = (NW'(rd_bytes) > need_q + NW'(HDR)) && (rem_w < (NW+1)'(UNITS));
	assign pay_w     = 32'(cur_q) * 32'(ALIGN_BYTES) + 32'(HDR);
	assign rel_hit   = rd_busy && (pay_w == 32'(rel_addr_q));
	assign steps_inc = (IW+1)'(steps_q) + (IW+1)'(1);
	assign last      = (steps_inc >= (IW+1)'(UNITS)) || (rd_next >= END_IDX);
	assign chg       = split_ok ? BW'(need_q) : rd_bytes;
	assign pm        = prev_valid_q && !prev_busy_q;
	assign free_w    = 32'(free_q);

	assign stat = '{is_rel: rel_q, hit: (rel_q ? rel_hit : fit), split: split_ok, last: last};

	always_comb begin
		we    = 1'b0;
		waddr = cur_q[AW-1:0];
		wdata = {rd_next, rd_bytes, 1'b1};
		re    = 1'b0;
		raddr = cur_q[AW-1:0];
		case (op)
			OP_RD_CUR: begin
				re = 1'b1;
			end
			OP_EVAL: begin
				if (!rel_q && fit) begin
					we = 1'b1;
					if (split_ok) begin
						waddr = rem_w[AW-1:0];
						wdata = {rd_next, BW'(NW'(rd_bytes) - need_q), 1'b0};
					end
				end
			end
			OP_WR_CUR: begin
				we    = 1'b1;
				wdata = {tgt_next_q, tgt_bytes_q, 1'b1};
			end
			OP_RD_NXT: begin
				re    = tgt_next_q < END_IDX;
				raddr = tgt_next_q[AW-1:0];
			end
			OP_WR_TGT: begin
				we    = 1'b1;
				waddr = tgt_q[AW-1:0];
				wdata = {tgt_next_q, tgt_bytes_q, 1'b0};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init0_q <= 1'b1;
			rsel0_q <= 1'b0;
			free_q  <= HSIZE_C;
		end else begin
			if (we && waddr == '0) begin
				init0_q <= 1'b0;
			end
			if (re) begin
				rsel0_q <= init0_q && (raddr == '0);
			end
			if (op == OP_EVAL && stat.hit) begin
				if (rel_q) begin
					free_q <= free_q + rd_bytes;
				end else begin
					free_q <= free_q - ((chg <= free_q) ? chg : free_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				rel_q        <= req_type;
				rel_addr_q   <= release_addr;
				units_q      <= NW'(prod_w >> RS);
				cur_q        <= '0;
				steps_q      <= '0;
				prev_valid_q <= 1'b0;
			end
			OP_PREP: begin
				need_q <= NW'(units_q * NW'(ALIGN_BYTES));
			end
			OP_EVAL: begin
				if (stat.hit) begin
					if (rel_q) begin
						tgt_q       <= pm ? prev_q : cur_q;
						tgt_next_q  <= rd_next;
						tgt_bytes_q <= pm ? prev_bytes_q + rd_bytes : rd_bytes;
					end else begin
						tgt_next_q  <= split_ok ? IW'(rem_w) : rd_next;
						tgt_bytes_q <= chg;
						r_status_q  <= RES_DONE;
						r_addr_q    <= pay_w[11:0];
					end
				end else begin
					prev_q       <= cur_q;
					prev_valid_q <= 1'b1;
					prev_busy_q  <= rd_busy;
					prev_bytes_q <= rd_bytes;
					cur_q        <= rd_next;
					steps_q      <= steps_inc[IW-1:0];
					if (last) begin
						r_status_q <= rel_q ? RES_NOTFOUND : RES_NOFIT;
						r_addr_q   <= '0;
					end
				end
			end
			OP_RD_NXT: begin
				nok_q <= tgt_next_q < END_IDX;
			end
			OP_EVAL_NXT: begin
				if (nok_q && !rd_busy) begin
					tgt_next_q  <= rd_next;
					tgt_bytes_q <= tgt_bytes_q + rd_bytes;
				end
			end
			OP_WR_TGT: begin
				r_status_q <= RES_DONE;
				r_addr_q   <= '0;
			end
			OP_OUT: begin
				o_status_q <= r_status_q;
				o_addr_q   <= r_addr_q;
				o_free_q   <= free_w[12:0];
			end
			default: begin
			end
		endcase
	end

	assign status       = o_status_q;
	assign payload_addr = o_addr_q;
	assign free_bytes   = o_free_q;

	// Free byte count never exceeds the heap.
	a_free_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= HSIZE_C)
		else $error("free byte count above heap size");

endmodule

// ===== rtl/ffha_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the allocator: sequences the chain walk and the header
// updates, and owns the handshakes. Depends on ffha_pkg.
module ffha_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output ffha_pkg::dp_op_t   op,
	input  ffha_pkg::dp_stat_t stat
);
	import ffha_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_PREP;
				end
			end
			S_PREP: state_d = S_RD;
			S_RD:   state_d = S_EV;
			S_EV: begin
				if (stat.hit) begin
					if (stat.is_rel) begin
						state_d = S_RD_N;
					end else if (stat.split) begin
						state_d = S_SPLIT_WR;
					end else begin
						state_d = S_FIN;
					end
				end else if (stat.last) begin
					state_d = S_FIN;
				end else begin
					state_d = S_RD;
				end
			end
			S_SPLIT_WR: state_d = S_FIN;
			S_RD_N:     state_d = S_EV_N;
			S_EV_N:     state_d = S_WR_T;
			S_WR_T:     state_d = S_FIN;
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		op = OP_NONE;
		case (state_q)
			S_IDLE:     op = in_valid ? OP_LOAD : OP_NONE;
			S_PREP:     op = OP_PREP;
			S_RD:       op = OP_RD_CUR;
			S_EV:       op = OP_EVAL;
			S_SPLIT_WR: op = OP_WR_CUR;
			S_RD_N:     op = OP_RD_NXT;
			S_EV_N:     op = OP_EVAL_NXT;
			S_WR_T:     op = OP_WR_TGT;
			S_FIN:      op = out_free ? OP_OUT : OP_NONE;
			default:    op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	// An accepted item always starts the size preparation step.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == S_PREP)
		else $error("accepted item did not start processing");

	// A finished item waits while the previous result is still held.
	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_valid && out_stall) |=> state_q == S_FIN)
		else $error("result overwritten while output stalled");

endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// First-fit heap allocator. Each item walks the block chain from entry 0,
// reading and evaluating one header per visit; a split writes the remainder
// header and then the shortened header, and a release reads the next header
// and writes the merge target. The next item can be accepted at the edge at
// which the result can first be taken, so items do not overlap, and an output
// stall also holds off the next item. The walk reads headers through the
// single read port of the header store.
// Reset: the heap is one free block and the free count is the heap size.
// Entry 0 is covered by a flag, so no clearing pass runs after reset.
module first_fit_heap_allocator #(
	parameter int HEAP_BYTES = 4096,
	parameter int ALIGN_BYTES = 8,
	parameter int HEADER_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [12:0] request_size,
	input  logic [11:0] release_addr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [11:0] payload_addr,
	output logic [12:0] free_bytes
);
	import ffha_pkg::*;

	// The controller issues one command per cycle; the datapath answers with
	// whether the header it just read matches, whether it must be split and
	// whether the walk has reached its end.
	dp_op_t   op;
	dp_stat_t stat;

	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.op       (op),
		.stat     (stat)
	);

	// The datapath keeps the chain headers, the walk position, the merge
	// target of a release and the result held for the output side.
	ffha_dp #(
		.HEAP_BYTES  (HEAP_BYTES),
		.ALIGN_BYTES (ALIGN_BYTES),
		.HEADER_BYTES(HEADER_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.stat        (stat),
		.req_type    (req_type),
		.request_size(request_size),
		.release_addr(release_addr),
		.status      (status),
		.payload_addr(payload_addr),
		.free_bytes  (free_bytes)
	);

	// A failed request, and every release, reports a zero payload address.
	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != RES_DONE) |-> payload_addr == '0)
		else $error("nonzero address on a failed request");

endmodule

// ===== dv/tb_first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_heap_allocator. It keeps its own
// model of the block chain and predicts every result. Also uses ffha_pkg.
module tb_first_fit_heap_allocator;
	import ffha_pkg::*;

	localparam int HEAP_BYTES = 4096;
	localparam int ALIGN_BYTES = 8;
	localparam int HEADER_BYTES = 8;
	localparam int UNITS = HEAP_BYTES / ALIGN_BYTES;
	localparam int HEAP_SIZE = UNITS * ALIGN_BYTES;
	localparam int HDR = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
	localparam int END_MARK = UNITS;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 2 * UNITS + 20;
	localparam int RANDOM_ITEMS = 1850;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	typedef struct packed {
		res_t        code;
		logic [11:0] addr;
		logic [12:0] free_cnt;
	} heap_result_t;

	// Predicts allocator results from a private copy of the block chain and
	// queues them until the block delivers its own.
	class heap_scoreboard;
		int unsigned link[UNITS];
		int unsigned bytes[UNITS];
		bit busy[UNITS];
		int unsigned free_cnt;
		heap_result_t pending[$];
		int errors;
		int unsigned live[$];

		function void init();
			for (int i = 0; i < UNITS; i++) begin
				link[i] = 0;
				bytes[i] = 0;
				busy[i] = 0;
			end
			link[0] = END_MARK;
			bytes[0] = HEAP_SIZE;
			free_cnt = HEAP_SIZE;
			errors = 0;
		endfunction

		function heap_result_t allocate(int unsigned size);
			heap_result_t r;
			int unsigned need;
			int unsigned cur;
			int unsigned rem;
			need = ((size + HDR + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
			cur = 0;
			r = '{code: RES_NOFIT, addr: '0, free_cnt: '0};
			for (int s = 0; s < UNITS && cur < UNITS; s++) begin
				if (!busy[cur] && bytes[cur] >= need) begin
					if (bytes[cur] > need + HDR) begin
						rem = cur + need / ALIGN_BYTES;
						if (rem < UNITS) begin
							link[rem] = link[cur];
							bytes[rem] = bytes[cur] - need;
							busy[rem] = 0;
							link[cur] = rem;
							bytes[cur] = need;
						end
					end
					free_cnt -= (bytes[cur] <= free_cnt) ? bytes[cur] : free_cnt;
					busy[cur] = 1;
					r.code = RES_DONE;
					r.addr = 12'(cur * ALIGN_BYTES + HDR);
					live.push_back(cur * ALIGN_BYTES + HDR);
					break;
				end
				cur = link[cur];
			end
			r.free_cnt = 13'(free_cnt);
			return r;
		endfunction

		function heap_result_t release_block(int unsigned addr);
			heap_result_t r;
			int unsigned cur;
			int unsigned prev;
			int unsigned nxt;
			cur = 0;
			prev = END_MARK;
			r = '{code: RES_NOTFOUND, addr: '0, free_cnt: '0};
			for (int s = 0; s < UNITS && cur < UNITS; s++) begin
				if (busy[cur] && cur * ALIGN_BYTES + HDR == addr) begin
					busy[cur] = 0;
					free_cnt += bytes[cur];
					if (prev < UNITS && !busy[prev]) begin
						link[prev] = link[cur];
						bytes[prev] += bytes[cur];
						cur = prev;
					end
					nxt = link[cur];
					if (nxt < UNITS && !busy[nxt]) begin
						link[cur] = link[nxt];
						bytes[cur] += bytes[nxt];
					end
					r.code = RES_DONE;
					foreach (live[i]) if (live[i] == addr) begin
						live.delete(i);
						break;
					end
					break;
				end
				prev = cur;
				cur = link[cur];
			end
			r.free_cnt = 13'(free_cnt);
			return r;
		endfunction

		function void note_request(logic kind, logic [12:0] size, logic [11:0] addr);
			if (kind == REQ_ALLOC)
				pending.push_back(allocate(size));
			else
				pending.push_back(release_block(addr));
		endfunction

		task report(string what, int got, int want);
			$display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
			errors++;
		endtask

		task check_result(logic [1:0] code, logic [11:0] addr, logic [12:0] free_cnt);
			heap_result_t e;
			if (pending.size() == 0) begin
				report("unexpected result, status", code, -1);
				return;
			end
			e = pending.pop_front();
			if (code !== e.code) report("status", code, e.code);
			if (addr !== e.addr) report("payload_addr", addr, e.addr);
			if (free_cnt !== e.free_cnt) report("free_bytes", free_cnt, e.free_cnt);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = REQ_ALLOC;
	logic [12:0] request_size = '0;
	logic [11:0] release_addr = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [11:0] payload_addr;
	logic [12:0] free_bytes;

	heap_scoreboard sb;
	int idle_cycles = 0;
	// Random idling is switched off for stretches to give back-to-back traffic.
	bit calm = 1'b0;

	always #4 clk = ~clk;

	first_fit_heap_allocator #(
		.HEAP_BYTES(HEAP_BYTES),
		.ALIGN_BYTES(ALIGN_BYTES),
		.HEADER_BYTES(HEADER_BYTES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.request_size(request_size),
		.release_addr(release_addr),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.payload_addr(payload_addr),
		.free_bytes(free_bytes)
	);

	// Both handshakes are sampled at the rising edge. Inputs are predicted on
	// acceptance so that the expected results stay in request order.
	always @(posedge clk) begin
		bit moved;
		moved = 1'b0;
		if (arst_n && in_valid && !in_stall) begin
			sb.note_request(req_type, request_size, release_addr);
			moved = 1'b1;
		end
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(status, payload_addr, free_bytes);
			moved = 1'b1;
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired with %0d results pending", sb.pending.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// The receiver draws a stall length for every result, at the falling edge.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = calm ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			// Hold the stall low until a result has gone through.
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Presents one item, held until accepted, after a random gap. The valid
	// of the previous item is dropped at the falling edge where the last call
	// returned, so the new item starts at a later falling edge.
	task automatic send_item(logic kind, logic [12:0] size, logic [11:0] addr);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		repeat (gap + 1) @(negedge clk);
		in_valid <= 1'b1;
		req_type <= kind;
		request_size <= size;
		release_addr <= addr;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	// Releases a granted payload, or now and then a bogus address.
	task automatic send_release();
		int unsigned pick;
		if (sb.live.size() != 0 && $urandom_range(0, 9) != 0) begin
			pick = $urandom_range(0, sb.live.size() - 1);
			send_item(REQ_RELEASE, 13'($urandom), 12'(sb.live[pick]));
		end else
			send_item(REQ_RELEASE, 13'($urandom), 12'($urandom));
	endtask

	task automatic send_alloc();
		logic [12:0] size;
		case ($urandom_range(0, 9))
			0: size = 13'($urandom_range(0, 4096));
			1: size = 13'($urandom);
			2: size = 13'($urandom_range(0, 8));
			default: size = 13'($urandom_range(1, 300));
		endcase
		send_item(REQ_ALLOC, size, 12'($urandom));
	endtask

	initial begin
		sb = new();
		sb.init();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: a fresh heap fits exactly heap size minus one header,
		// one byte more misses, and the whole range of both fields is touched.
		send_item(REQ_ALLOC, 13'(HEAP_SIZE - HDR + 1), 12'hfff);
		send_item(REQ_ALLOC, 13'h1fff, 12'h000);
		send_item(REQ_ALLOC, 13'(HEAP_SIZE - HDR), 12'h000);
		send_item(REQ_RELEASE, 13'h1fff, 12'(HDR));
		// Release of offset zero, a freed block and an unaligned offset.
		send_item(REQ_RELEASE, 13'h0000, 12'h000);
		send_item(REQ_RELEASE, 13'h0000, 12'(HDR));
		send_item(REQ_RELEASE, 13'h0000, 12'hfff);
		// Zero-size and small requests that split the heap, and an interior
		// offset that must not match.
		send_item(REQ_ALLOC, 13'h0000, 12'hfff);
		send_item(REQ_ALLOC, 13'h0001, 12'h000);
		send_item(REQ_ALLOC, 13'd100, 12'h000);
		send_item(REQ_RELEASE, 13'h0000, 12'(2 * HDR + 4));
		// Release a header offset, the first block and an offset inside a block.
		send_item(REQ_RELEASE, 13'h0000, 12'(HDR + 16));
		send_item(REQ_RELEASE, 13'h0000, 12'(HDR));
		send_item(REQ_RELEASE, 13'h0000, 12'(HDR + 32));
		send_item(REQ_ALLOC, 13'(HEAP_SIZE - 3 * HDR), 12'h000);
		send_item(REQ_ALLOC, 13'h0000, 12'h000);
		send_item(REQ_ALLOC, 13'h0000, 12'h000);
		send_item(REQ_RELEASE, 13'h0000, 12'(HDR));
		send_item(REQ_RELEASE, 13'h0000, 12'(HEAP_SIZE - 2 * HDR + HDR));
		send_item(REQ_RELEASE, 13'h0000, 12'(HEAP_SIZE - HDR + HDR));

		// The sender holds back until the block has answered everything.
		wait_drained();

		// Random part: phases lean toward allocation, then release, so the
		// heap fills, fragments and empties again.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 200 == 0) calm = ($urandom_range(0, 3) == 0);
			if (((n / 150) % 2) == 0 ? ($urandom_range(0, 9) < 7)
				: ($urandom_range(0, 9) < 3))
				send_alloc();
			else
				send_release();
			if (n % 500 == 499) wait_drained();
		end
		calm = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/ffha_dp.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator.sv
dv/tb_first_fit_heap_allocator.sv
